[sv/rrct_pkg.sv]
// rrct_pkg: shared types, constants and helpers for the ram range coalescing table
// used by rrct_match and ram_range_coalescing_table
package rrct_pkg;

   localparam int DEFAULT_MAX_AREAS = 32;
   localparam int PAGE_SHIFT        = 12;

   // result status codes
   localparam logic [2:0] ST_MERGE_BELOW = 3'd0;
   localparam logic [2:0] ST_MERGE_ABOVE = 3'd1;
   localparam logic [2:0] ST_APPEND      = 3'd2;
   localparam logic [2:0] ST_SKIPPED     = 3'd3;
   localparam logic [2:0] ST_FULL        = 3'd4;
   localparam logic [2:0] ST_READ_DONE   = 3'd5;

   // request selector carried on tuser
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_READ   = 1'b1;

   // usable memory type codes
   localparam logic [7:0] MT_LOADER_CODE   = 8'd1;
   localparam logic [7:0] MT_LOADER_DATA   = 8'd2;
   localparam logic [7:0] MT_BOOT_CODE     = 8'd3;
   localparam logic [7:0] MT_BOOT_DATA     = 8'd4;
   localparam logic [7:0] MT_CONVENTIONAL  = 8'd7;
   localparam logic [7:0] MT_ACPI_RECLAIM  = 8'd9;
   localparam logic [7:0] MT_PERSISTENT    = 8'd14;

   typedef struct packed {
      logic below;   // area starts where the descriptor ends
      logic above;   // area ends where the descriptor starts
   } match_type;

   function automatic logic type_usable(input logic [7:0] mem_type);
      logic ok;
      ok = (mem_type == MT_LOADER_CODE)  || (mem_type == MT_LOADER_DATA) ||
           (mem_type == MT_BOOT_CODE)    || (mem_type == MT_BOOT_DATA)   ||
           (mem_type == MT_CONVENTIONAL) || (mem_type == MT_ACPI_RECLAIM) ||
           (mem_type == MT_PERSISTENT);
      return ok;
   endfunction

endpackage

[sv/ram_range_coalescing_table.sv]
// ram_range_coalescing_table: top level, sequencer that scans the area table
// depends on rrct_pkg, rrct_area_mem, rrct_match
//
//   channel  dir  ports                     handshake
//   req      in   req_tvalid/tready/tdata   func on tuser, descriptor or read slot on tdata
//   rsp      out  rsp_tvalid/tready/tdata   status on tuser, area fields on tdata
//
// insert: one stored area per cycle through the registered read port and the shared
// compare, then write-back and result load
// read: registered read, then result load; skipped or full insert: result load only
// every result shows in the same cycle that req_tready returns high again
// reset clears the sequencer, area count and output valid; table words stay unset
// a result waiting on rsp_tready holds the next one in the done state, req_tready low
module ram_range_coalescing_table #(
   parameter int MAX_AREAS = rrct_pkg::DEFAULT_MAX_AREAS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // mem_type[7:0], phys_start[71:8], num_pages[123:72], read_index[128:124], zero fill
   input  logic [135:0] req_tdata,
   // func
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // area_index[4:0], area_start[68:5], area_size[132:69], area_count[138:133], zero fill
   output logic [143:0] rsp_tdata,
   // status
   output logic [2:0]   rsp_tuser
);

   localparam int IDX_W = (MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1;
   localparam int CNT_W = $clog2(MAX_AREAS + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_WRITE = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [7:0]  in_type;
   logic [63:0] in_start;
   logic [51:0] in_pages;
   logic [4:0]  in_ridx;
   logic [63:0] in_dsize;
   logic        req_fire;

   assign in_type  = req_tdata[7:0];
   assign in_start = req_tdata[71:8];
   assign in_pages = req_tdata[123:72];
   assign in_ridx  = req_tdata[128:124];
   assign in_dsize = {in_pages, {rrct_pkg::PAGE_SHIFT{1'b0}}};

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             cmp_valid_ff, cmp_valid_in;
   logic [CNT_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic [63:0]      pstart_ff, pstart_in;
   logic [63:0]      dsize_ff, dsize_in;
   logic [63:0]      dend_ff, dend_in;
   logic [2:0]       kind_ff, kind_in;
   logic [CNT_W-1:0] hit_idx_ff, hit_idx_in;
   logic [63:0]      old_start_ff, old_start_in;
   logic [63:0]      old_size_ff, old_size_in;
   logic [4:0]       rd_idx_ff, rd_idx_in;
   logic             rd_oob_ff, rd_oob_in;
   logic [2:0]       res_status_ff, res_status_in;
   logic [4:0]       res_index_ff, res_index_in;
   logic [63:0]      res_start_ff, res_start_in;
   logic [63:0]      res_size_ff, res_size_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [143:0]     rsp_data_ff, rsp_data_in;
   logic [2:0]       rsp_user_ff, rsp_user_in;

   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   logic [63:0]      mem_wr_start;
   logic [63:0]      mem_wr_size;
   logic [IDX_W-1:0] mem_rd_addr;
   logic [63:0]      mem_rd_start;
   logic [63:0]      mem_rd_size;
   logic [63:0]      new_size;
   rrct_pkg::match_type hit;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // idle issues the read slot or the first area; scan issues the next area
   assign mem_rd_addr = (state_ff == S_IDLE)
                        ? ((req_tuser == rrct_pkg::FUNC_READ) ? IDX_W'(in_ridx) : '0)
                        : scan_ff[IDX_W-1:0];

   assign new_size     = old_size_ff + dsize_ff;
   assign mem_wr_en    = (state_ff == S_WRITE);
   assign mem_wr_addr  = hit_idx_ff[IDX_W-1:0];
   assign mem_wr_start = (kind_ff == rrct_pkg::ST_MERGE_ABOVE) ? old_start_ff : pstart_ff;
   assign mem_wr_size  = new_size;

   rrct_area_mem #(
      .DEPTH (MAX_AREAS),
      .IDX_W (IDX_W)
   ) u_mem (
      .clock    (clock),
      .wr_en    (mem_wr_en),
      .wr_addr  (mem_wr_addr),
      .wr_start (mem_wr_start),
      .wr_size  (mem_wr_size),
      .rd_addr  (mem_rd_addr),
      .rd_start (mem_rd_start),
      .rd_size  (mem_rd_size)
   );

   rrct_match u_match (
      .area_start (mem_rd_start),
      .area_size  (mem_rd_size),
      .desc_start (pstart_ff),
      .desc_top   (dend_ff),
      .hit        (hit)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      cmp_valid_in  = cmp_valid_ff;
      cmp_idx_in    = cmp_idx_ff;
      pstart_in     = pstart_ff;
      dsize_in      = dsize_ff;
      dend_in       = dend_ff;
      kind_in       = kind_ff;
      hit_idx_in    = hit_idx_ff;
      old_start_in  = old_start_ff;
      old_size_in   = old_size_ff;
      rd_idx_in     = rd_idx_ff;
      rd_oob_in     = rd_oob_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      res_start_in  = res_start_ff;
      res_size_in   = res_size_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               pstart_in  = in_start;
               dsize_in   = in_dsize;
               dend_in    = in_start + in_dsize;
               rd_idx_in  = in_ridx;
               rd_oob_in  = (32'(in_ridx) >= 32'(MAX_AREAS));
               res_index_in = '0;
               res_start_in = '0;
               res_size_in  = '0;
               if (req_tuser == rrct_pkg::FUNC_READ) begin
                  state_in = S_READ;
               end else if (!rrct_pkg::type_usable(in_type)) begin
                  res_status_in = rrct_pkg::ST_SKIPPED;
                  state_in      = S_DONE;
               end else if (32'(count_ff) >= 32'(MAX_AREAS)) begin
                  res_status_in = rrct_pkg::ST_FULL;
                  state_in      = S_DONE;
               end else begin
                  // area 0 read is already issued this cycle
                  cmp_valid_in = (count_ff != '0);
                  cmp_idx_in   = '0;
                  scan_in      = CNT_W'(1);
                  state_in     = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (cmp_valid_ff && (hit.below || hit.above)) begin
               kind_in      = hit.below ? rrct_pkg::ST_MERGE_BELOW : rrct_pkg::ST_MERGE_ABOVE;
               hit_idx_in   = cmp_idx_ff;
               old_start_in = mem_rd_start;
               old_size_in  = mem_rd_size;
               state_in     = S_WRITE;
            end else if (!cmp_valid_ff) begin
               kind_in      = rrct_pkg::ST_APPEND;
               hit_idx_in   = count_ff;
               old_start_in = '0;
               old_size_in  = '0;
               state_in     = S_WRITE;
            end else begin
               cmp_valid_in = (scan_ff < count_ff);
               cmp_idx_in   = scan_ff;
               scan_in      = scan_ff + CNT_W'(1);
            end
         end
         S_WRITE: begin
            res_status_in = kind_ff;
            res_index_in  = 5'(hit_idx_ff);
            res_start_in  = mem_wr_start;
            res_size_in   = new_size;
            if (kind_ff == rrct_pkg::ST_APPEND) begin
               count_in = count_ff + CNT_W'(1);
            end
            state_in = S_DONE;
         end
         S_READ: begin
            res_status_in = rrct_pkg::ST_READ_DONE;
            res_index_in  = rd_idx_ff;
            res_start_in  = rd_oob_ff ? '0 : mem_rd_start;
            res_size_in   = rd_oob_ff ? '0 : mem_rd_size;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = res_status_ff;
               rsp_data_in  = {5'd0, 6'(count_ff), res_size_ff, res_start_ff, res_index_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      cmp_valid_ff  <= cmp_valid_in;
      cmp_idx_ff    <= cmp_idx_in;
      pstart_ff     <= pstart_in;
      dsize_ff      <= dsize_in;
      dend_ff       <= dend_in;
      kind_ff       <= kind_in;
      hit_idx_ff    <= hit_idx_in;
      old_start_ff  <= old_start_in;
      old_size_ff   <= old_size_in;
      rd_idx_ff     <= rd_idx_in;
      rd_oob_ff     <= rd_oob_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      res_start_ff  <= res_start_in;
      res_size_ff   <= res_size_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

[sv/rrct_area_mem.sv]
// rrct_area_mem: area table storage, start and size words, one write and one read port
// read data registered; no dependencies
module rrct_area_mem #(
   parameter int DEPTH = 32,
   parameter int IDX_W = 5
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [63:0]      wr_start,
   input  logic [63:0]      wr_size,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [63:0]      rd_start,
   output logic [63:0]      rd_size
);

   logic [63:0] start_mem [DEPTH];
   logic [63:0] size_mem  [DEPTH];
   logic [63:0] rd_start_ff;
   logic [63:0] rd_size_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         start_mem[wr_addr] <= wr_start;
         size_mem[wr_addr]  <= wr_size;
      end
      rd_start_ff <= start_mem[rd_addr];
      rd_size_ff  <= size_mem[rd_addr];
   end

   assign rd_start = rd_start_ff;
   assign rd_size  = rd_size_ff;

endmodule

[sv/rrct_match.sv]
// rrct_match: adjacency compare of one stored area against the pending descriptor
// depends on rrct_pkg
module rrct_match (
   input  logic [63:0]         area_start,
   input  logic [63:0]         area_size,
   input  logic [63:0]         desc_start,
   input  logic [63:0]         desc_top,
   output rrct_pkg::match_type hit
);

   logic [63:0] area_end;

   // modular 64-bit end address
   assign area_end  = area_start + area_size;
   assign hit.below = (area_start == desc_top);
   assign hit.above = (area_end == desc_start);

endmodule

[test/ram_range_coalescing_table_tb.sv]
// testbench for ram_range_coalescing_table: directed and random descriptor inserts and reads
// checked against an in-bench table predictor; depends on rrct_pkg and the ram_range_coalescing_table rtl
module ram_range_coalescing_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_AREAS    = rrct_pkg::DEFAULT_MAX_AREAS;
   localparam int RANDOM_ITEMS = 1700;
   localparam int FILL_SPAN    = 1300;   // random items over which the table fills up
   localparam int PLAN_SIDE    = 0;      // table copy used to shape the stimulus
   localparam int CHECK_SIDE   = 1;      // table copy advanced on accepted transactions
   localparam logic [7:0] USABLE_CODES [7] = '{rrct_pkg::MT_LOADER_CODE,
      rrct_pkg::MT_LOADER_DATA, rrct_pkg::MT_BOOT_CODE, rrct_pkg::MT_BOOT_DATA,
      rrct_pkg::MT_CONVENTIONAL, rrct_pkg::MT_ACPI_RECLAIM, rrct_pkg::MT_PERSISTENT};

   typedef struct packed {
      logic        func;
      logic [7:0]  mem_type;
      logic [63:0] phys_start;
      logic [51:0] num_pages;
      logic [4:0]  read_index;
   } descriptor_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [4:0]  area_index;
      logic [63:0] area_start;
      logic [63:0] area_size;
      logic [5:0]  area_count;
   } area_result_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [135:0] req_tdata  = '0;   // mem_type, phys_start, num_pages, read_index, zero fill
   logic         req_tuser  = 1'b0; // func
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [143:0] rsp_tdata;         // area_index, area_start, area_size, area_count, zero fill
   logic [2:0]   rsp_tuser;         // status

   logic [63:0]  start_tbl [2][MAX_AREAS];
   logic [63:0]  size_tbl  [2][MAX_AREAS];
   int unsigned  area_cnt  [2];

   descriptor_type  pending_desc [$];
   area_result_type expected_areas [$];
   descriptor_type  cur_desc;
   int unsigned  total_items = 0;
   int unsigned  accepted_n  = 0;
   int unsigned  mismatches  = 0;

   ram_range_coalescing_table #(
      .MAX_AREAS (MAX_AREAS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   function automatic logic ram_type_ok(input logic [7:0] code);
      case (code)
         rrct_pkg::MT_LOADER_CODE, rrct_pkg::MT_LOADER_DATA, rrct_pkg::MT_BOOT_CODE,
         rrct_pkg::MT_BOOT_DATA, rrct_pkg::MT_CONVENTIONAL, rrct_pkg::MT_ACPI_RECLAIM,
         rrct_pkg::MT_PERSISTENT: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // applies one transaction to one copy of the area table and returns its result
   function automatic area_result_type coalesce_step(input int side, input descriptor_type d);
      area_result_type r;
      logic [63:0]  dsize;
      logic [63:0]  dend;
      int           hit;
      r   = '0;
      hit = -1;
      if (d.func == rrct_pkg::FUNC_READ) begin
         r.status     = rrct_pkg::ST_READ_DONE;
         r.area_index = d.read_index;
         if (d.read_index < MAX_AREAS) begin
            r.area_start = start_tbl[side][d.read_index];
            r.area_size  = size_tbl[side][d.read_index];
         end
      end else if (!ram_type_ok(d.mem_type)) begin
         r.status = rrct_pkg::ST_SKIPPED;
      end else if (area_cnt[side] >= MAX_AREAS) begin
         r.status = rrct_pkg::ST_FULL;
      end else begin
         dsize = 64'(d.num_pages) << rrct_pkg::PAGE_SHIFT;
         dend  = d.phys_start + dsize;
         // first area touching the descriptor wins, lower edge tested before upper
         for (int i = 0; i < area_cnt[side]; i++) begin
            if (hit < 0 && (start_tbl[side][i] == dend ||
                            start_tbl[side][i] + size_tbl[side][i] == d.phys_start))
               hit = i;
         end
         if (hit < 0) begin
            hit                   = area_cnt[side];
            start_tbl[side][hit]  = d.phys_start;
            size_tbl[side][hit]   = dsize;
            area_cnt[side]        = area_cnt[side] + 1;
            r.status              = rrct_pkg::ST_APPEND;
         end else if (start_tbl[side][hit] == dend) begin
            start_tbl[side][hit]  = d.phys_start;
            size_tbl[side][hit]   = size_tbl[side][hit] + dsize;
            r.status              = rrct_pkg::ST_MERGE_BELOW;
         end else begin
            size_tbl[side][hit]   = size_tbl[side][hit] + dsize;
            r.status              = rrct_pkg::ST_MERGE_ABOVE;
         end
         r.area_index = 5'(hit);
         r.area_start = start_tbl[side][hit];
         r.area_size  = size_tbl[side][hit];
      end
      r.area_count = 6'(area_cnt[side]);
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [51:0] rand_pages();
      logic [63:0] r;
      r = rand64();
      if ($urandom_range(0, 15) == 0)
         return r[51:0];
      return 52'($urandom_range(0, 64));
   endfunction

   function automatic void plan_item(input descriptor_type d);
      void'(coalesce_step(PLAN_SIDE, d));
      pending_desc.push_back(d);
   endfunction

   function automatic void plan_insert(input logic [7:0] code, input logic [63:0] base,
                                       input logic [51:0] pages);
      descriptor_type d;
      d.func       = rrct_pkg::FUNC_INSERT;
      d.mem_type   = code;
      d.phys_start = base;
      d.num_pages  = pages;
      d.read_index = 5'($urandom_range(0, 31));
      plan_item(d);
   endfunction

   // slot must already hold an area; the other fields are don't-care noise
   function automatic void plan_read(input int unsigned slot);
      descriptor_type d;
      d.func       = rrct_pkg::FUNC_READ;
      d.mem_type   = 8'($urandom_range(0, 255));
      d.phys_start = rand64();
      d.num_pages  = rand_pages();
      d.read_index = 5'(slot);
      plan_item(d);
   endfunction

   // percentage of cycles idle: sender when sender_side is set, else receiver
   function automatic int unsigned idle_pct(input bit sender_side);
      int unsigned stage;
      stage = (total_items == 0) ? 0 : accepted_n * 4 / total_items;
      case (stage)
         0:       return 0;
         1:       return sender_side ? 72 : 0;
         2:       return sender_side ? 0 : 72;
         default: return 33;
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
   endfunction

   // request driver: predicts on acceptance, then loads the next pending transaction
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_areas.push_back(coalesce_step(CHECK_SIDE, cur_desc));
            accepted_n++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_desc.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
               cur_desc   = pending_desc.pop_front();
               req_tdata  <= {7'b0, cur_desc.read_index, cur_desc.num_pages,
                              cur_desc.phys_start, cur_desc.mem_type};
               req_tuser  <= cur_desc.func;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor and backpressure
   always @(posedge clock) begin
      area_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_areas.size() == 0) begin
               mismatches++;
               $display("%0t ns: unexpected result, expected none, actual status %0d tdata 0x%0h",
                        $time, rsp_tuser, rsp_tdata);
            end else begin
               want = expected_areas.pop_front();
               check_field("status", 64'(want.status), 64'(rsp_tuser));
               check_field("area_index", 64'(want.area_index), 64'(rsp_tdata[4:0]));
               check_field("area_start", want.area_start, rsp_tdata[68:5]);
               check_field("area_size", want.area_size, rsp_tdata[132:69]);
               check_field("area_count", 64'(want.area_count), 64'(rsp_tdata[138:133]));
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
      end
   end

   initial begin
      int unsigned roll;
      int unsigned cnt;
      int unsigned target;
      int unsigned slot;
      logic [7:0]  code;
      logic [51:0] pages;
      area_cnt[PLAN_SIDE]  = 0;
      area_cnt[CHECK_SIDE] = 0;

      // directed: skips, every merge direction, zero size, address wrap, widest size, reads
      plan_insert(8'd0, 64'h0, 52'h0);
      plan_insert(8'd255, '1, '1);
      plan_insert(rrct_pkg::MT_LOADER_CODE, 64'h1000_0000, 52'd16);
      plan_insert(rrct_pkg::MT_LOADER_DATA, 64'h1001_0000, 52'd1);
      plan_insert(rrct_pkg::MT_BOOT_CODE, 64'h0fff_f000, 52'd1);
      plan_insert(rrct_pkg::MT_BOOT_DATA, 64'h8000_0000_0000_0000, 52'd0);
      plan_insert(rrct_pkg::MT_BOOT_DATA, 64'h8000_0000_0000_0000, 52'd0);
      plan_insert(rrct_pkg::MT_CONVENTIONAL, 64'hffff_ffff_ffff_f000, 52'd1);
      plan_insert(rrct_pkg::MT_ACPI_RECLAIM, 64'h0, 52'd5);   // grows the area that wrapped to zero
      plan_insert(rrct_pkg::MT_PERSISTENT, 64'h0123_4567_89ab_c000, '1);
      for (int i = 0; i < 4; i++)
         plan_read(i);
      plan_insert(8'd5, rand64(), rand_pages());
      plan_insert(8'd6, rand64(), rand_pages());
      plan_insert(8'd8, rand64(), rand_pages());
      plan_insert(8'd10, rand64(), rand_pages());
      plan_insert(8'd11, rand64(), rand_pages());
      plan_insert(8'd12, rand64(), rand_pages());
      plan_insert(8'd13, rand64(), rand_pages());
      plan_insert(8'd15, rand64(), rand_pages());

      // random: mostly descriptors aimed at stored areas, fresh ones pace the fill
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         cnt    = area_cnt[PLAN_SIDE];
         target = 1 + n * MAX_AREAS / FILL_SPAN;
         roll   = $urandom_range(0, 99);
         if (roll < 12 && cnt > 0) begin
            plan_read($urandom_range(0, cnt - 1));
         end else if (roll < 22) begin
            do code = 8'($urandom_range(0, 255)); while (ram_type_ok(code));
            plan_insert(code, rand64(), rand_pages());
         end else begin
            code  = USABLE_CODES[$urandom_range(0, 6)];
            pages = rand_pages();
            if (cnt < target || cnt == 0) begin
               plan_insert(code, rand64(), pages);
            end else begin
               slot = $urandom_range(0, cnt - 1);
               if ($urandom_range(0, 1) == 0)
                  plan_insert(code, start_tbl[PLAN_SIDE][slot] -
                              (64'(pages) << rrct_pkg::PAGE_SHIFT), pages);
               else
                  plan_insert(code, start_tbl[PLAN_SIDE][slot] + size_tbl[PLAN_SIDE][slot],
                              pages);
            end
         end
      end
      total_items = pending_desc.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_desc.size() > 0 || req_tvalid)
         @(posedge clock);
      while (expected_areas.size() > 0)
         @(posedge clock);
      repeat (50) @(posedge clock);

      if (mismatches == 0)
         $display("ram_range_coalescing_table regression: pass");
      else
         $display("ram_range_coalescing_table regression: fail");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("ram_range_coalescing_table regression: fail");
      $finish;
   end

endmodule
